### hdl/flmc_pkg.sv
package flmc_pkg;

  localparam int REQ_BITS  = 4;
  localparam int ARG_BITS  = 16;
  localparam int CFG_BITS  = 8;
  localparam int HOLD_BITS = 5;
  localparam int MODE_BITS = 2;
  localparam int IDX_BITS  = 2;
  localparam int GAP_BITS  = 3;

  // event codes
  localparam logic [REQ_BITS-1:0] EV_PRESS      = 4'd0;
  localparam logic [REQ_BITS-1:0] EV_RELEASE    = 4'd1;
  localparam logic [REQ_BITS-1:0] EV_CLICK1     = 4'd2;
  localparam logic [REQ_BITS-1:0] EV_CLICK2     = 4'd3;
  localparam logic [REQ_BITS-1:0] EV_CLICK3     = 4'd4;
  localparam logic [REQ_BITS-1:0] EV_CLICK4     = 4'd5;
  localparam logic [REQ_BITS-1:0] EV_HOLD       = 4'd6;
  localparam logic [REQ_BITS-1:0] EV_HOLD_REL   = 4'd7;
  localparam logic [REQ_BITS-1:0] EV_CLICK_HOLD = 4'd8;
  localparam logic [REQ_BITS-1:0] EV_TEMP_HIGH  = 4'd9;
  localparam logic [REQ_BITS-1:0] EV_TEMP_LOW   = 4'd10;
  localparam logic [REQ_BITS-1:0] EV_TICK       = 4'd11;
  localparam logic [REQ_BITS-1:0] EV_LOW_VOLT   = 4'd12;

  // light modes
  localparam logic [MODE_BITS-1:0] MODE_OFF    = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_STEADY = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_STROBE = 2'd2;

  // register indexes
  localparam logic [IDX_BITS-1:0] CFG_MAX_LEVEL = 2'd0;
  localparam logic [IDX_BITS-1:0] CFG_SCM       = 2'd1;
  localparam logic [IDX_BITS-1:0] CFG_HOLD      = 2'd2;

  localparam logic [CFG_BITS-1:0] MAX_LEVEL_RST = 8'd150;
  localparam logic [CFG_BITS-1:0] SCM_RST       = 8'd65;
  localparam logic [CFG_BITS-1:0] HOLD_RST      = 8'd24;

  localparam logic [GAP_BITS-1:0] GAP_RST        = 3'd2;
  localparam logic [GAP_BITS:0]   GAP_WRAP       = 4'd6;
  localparam logic [GAP_BITS-1:0] GAP_FAST_LIMIT = 3'd3;

  localparam logic [HOLD_BITS-1:0] BLINK_RAMP_MS = 5'd7;
  localparam logic [HOLD_BITS-1:0] BLINK_FOUR_MS = 5'd20;

  // x/6 for 8-bit x as (x*171)>>10
  localparam logic [CFG_BITS-1:0] RECIP6       = 8'd171;
  localparam int                  RECIP6_SHIFT = 10;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_start;
    logic exec;
    logic out_load;
    logic out_sel;
  } flmc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic two_res;
    logic out_free;
  } flmc_stat_t;

endpackage

### hdl/flmc_mod.sv
module flmc_mod
  import flmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [ARG_BITS-1:0] dividend_i,
  input  logic [CFG_BITS-1:0] divisor_i,
  output logic                busy_o,
  output logic                rem_zero_o
);

  localparam int CNT_BITS = $clog2(ARG_BITS + 1);

  logic                busy_q, busy_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [ARG_BITS-1:0] quo_q;
  logic [CFG_BITS-1:0] rem_q, div_q, rem_d;
  logic [CFG_BITS:0]   trial, trial_sub;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    trial     = {rem_q, quo_q[ARG_BITS-1]};
    trial_sub = trial - {1'b0, div_q};
    if (trial >= {1'b0, div_q}) begin
      rem_d = trial_sub[CFG_BITS-1:0];
    end else begin
      rem_d = trial[CFG_BITS-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(ARG_BITS);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[ARG_BITS-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

### hdl/flmc_datapath.sv
module flmc_datapath
  import flmc_pkg::*;
#(
  parameter int LEVEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  flmc_cmd_t             cmd_i,
  output flmc_stat_t            stat_o,
  input  logic                  cfg_we_i,
  input  logic [IDX_BITS-1:0]   cfg_idx_i,
  input  logic [CFG_BITS-1:0]   cfg_data_i,
  input  logic [REQ_BITS-1:0]   req_type_i,
  input  logic [ARG_BITS-1:0]   arg_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [LEVEL_BITS-1:0] level_o,
  output logic                  flash_o,
  output logic [HOLD_BITS-1:0]  hold_ms_o,
  output logic [MODE_BITS-1:0]  mode_o,
  output logic                  unhandled_o,
  output logic                  last_o
);

  localparam int WW = (LEVEL_BITS > ARG_BITS ? LEVEL_BITS : ARG_BITS) + 1;
  typedef logic [WW-1:0]         word_t;
  typedef logic [LEVEL_BITS-1:0] lvl_t;

  localparam word_t LMAX_W = word_t'((1 << LEVEL_BITS) - 1);
  localparam word_t ONE_W  = word_t'(1);
  localparam lvl_t  LV_ONE = lvl_t'(1);

  // configuration
  logic [CFG_BITS-1:0] maxl_q, scm_q, hold_q;

  // light state
  logic [MODE_BITS-1:0] mode_q, mode_d;
  lvl_t                 cur_q, cur_d, rem_q, rem_d, tgt_q, tgt_d;
  logic                 coarse_q, coarse_d;
  logic [GAP_BITS-1:0]  gap_q, gap_d, frame_q, frame_d;

  // latched event and per-event constants
  logic [REQ_BITS-1:0]  ev_q;
  logic [ARG_BITS-1:0]  arg_q;
  logic [CFG_BITS-1:0]  step_q, sixth_q;

  logic [2*CFG_BITS-1:0] prod6;
  logic [CFG_BITS-1:0]   sixth_c, step_c, divisor_c;
  logic                  need_div;
  logic                  div_busy, rem_zero;

  // result buffer
  lvl_t                 r0_lvl_q, r1_lvl_q;
  logic                 r0_flash_q, r0_last_q, two_q;
  logic [HOLD_BITS-1:0] r0_hold_q;
  logic [MODE_BITS-1:0] r_mode_q;
  logic                 r_unh_q;

  // output register
  logic                 out_valid_q;
  lvl_t                 out_lvl_q;
  logic                 out_flash_q, out_unh_q, out_last_q;
  logic [HOLD_BITS-1:0] out_hold_q;
  logic [MODE_BITS-1:0] out_mode_q;
  logic                 out_free;

  // event step signals
  word_t               cur_w, rem_w, tgt_w, maxl_w, scm_w, step_w, arg_w;
  word_t               quarter_w, sixth_w, hold_w;
  word_t               v_w, st_lvl;
  lvl_t                r_l, st_m;
  logic [GAP_BITS:0]   g_w;
  logic [GAP_BITS-1:0] f_w;
  logic                handled, pulsed, blink, go_st;
  logic [HOLD_BITS-1:0] blink_ms, pulse_ms;

  assign prod6   = (2*CFG_BITS)'(maxl_q) * (2*CFG_BITS)'(RECIP6);
  assign sixth_c = CFG_BITS'(prod6 >> RECIP6_SHIFT);
  assign step_c  = (coarse_q && (sixth_c != '0)) ? sixth_c : 8'd1;

  assign divisor_c = (mode_q == MODE_STEADY) ? step_c : ((hold_q != '0) ? hold_q : 8'd1);
  assign need_div  = ((mode_q == MODE_STEADY) && ((ev_q == EV_HOLD) || (ev_q == EV_CLICK_HOLD)))
                  || ((mode_q == MODE_STROBE) && (ev_q == EV_HOLD));

  flmc_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (arg_q),
    .divisor_i  (divisor_c),
    .busy_o     (div_busy),
    .rem_zero_o (rem_zero)
  );

  assign cur_w     = word_t'(cur_q);
  assign rem_w     = word_t'(rem_q);
  assign tgt_w     = word_t'(tgt_q);
  assign maxl_w    = word_t'(maxl_q);
  assign scm_w     = word_t'(scm_q);
  assign step_w    = word_t'(step_q);
  assign arg_w     = word_t'(arg_q);
  assign quarter_w = word_t'(maxl_q >> 2);
  assign sixth_w   = word_t'(sixth_q);
  assign hold_w    = word_t'(hold_q);

  always_comb begin
    mode_d   = mode_q;
    cur_d    = cur_q;
    rem_d    = rem_q;
    tgt_d    = tgt_q;
    coarse_d = coarse_q;
    gap_d    = gap_q;
    frame_d  = frame_q;
    handled  = 1'b1;
    pulsed   = 1'b0;
    blink    = 1'b0;
    blink_ms = '0;
    pulse_ms = '0;
    go_st    = 1'b0;
    st_lvl   = '0;
    v_w      = '0;
    r_l      = '0;
    st_m     = '0;
    g_w      = '0;
    f_w      = '0;

    priority if (ev_q == EV_LOW_VOLT) begin
      if (mode_q == MODE_STROBE) begin
        go_st  = 1'b1;
        st_lvl = sixth_w;
      end else if (mode_q == MODE_STEADY) begin
        if (cur_w > ONE_W) begin
          cur_d = cur_q >> 1;
        end else begin
          mode_d = MODE_OFF;
          cur_d  = '0;
        end
      end
    end else if (mode_q == MODE_OFF) begin
      unique case (ev_q)
        EV_PRESS:    cur_d = LV_ONE;
        EV_RELEASE:  cur_d = rem_q;
        EV_CLICK1: begin
          go_st  = 1'b1;
          st_lvl = rem_w;
        end
        EV_CLICK2, EV_CLICK_HOLD: begin
          go_st  = 1'b1;
          st_lvl = maxl_w;
        end
        EV_CLICK3: begin
          frame_d = '0;
          mode_d  = MODE_STROBE;
        end
        EV_HOLD: begin
          if (arg_w >= hold_w) begin
            go_st  = 1'b1;
            st_lvl = ONE_W;
          end
        end
        EV_HOLD_REL: begin
          go_st  = 1'b1;
          st_lvl = ONE_W;
        end
        default: handled = 1'b0;
      endcase
    end else if (mode_q == MODE_STEADY) begin
      unique case (ev_q)
        EV_CLICK1: begin
          mode_d = MODE_OFF;
          cur_d  = '0;
        end
        EV_CLICK2: begin
          if (cur_w < maxl_w) begin
            rem_d = cur_q;
            tgt_d = maxl_w[LEVEL_BITS-1:0];
            cur_d = maxl_w[LEVEL_BITS-1:0];
          end else begin
            tgt_d = rem_q;
            cur_d = rem_q;
          end
        end
        EV_CLICK3: begin
          frame_d = '0;
          mode_d  = MODE_STROBE;
        end
        EV_CLICK4: begin
          coarse_d = ~coarse_q;
          blink    = 1'b1;
          blink_ms = BLINK_FOUR_MS;
          cur_d    = rem_q;
        end
        EV_HOLD: begin
          if (rem_zero) begin
            v_w = cur_w + step_w;
            r_l = (v_w < maxl_w) ? v_w[LEVEL_BITS-1:0] : maxl_w[LEVEL_BITS-1:0];
            rem_d = r_l;
            tgt_d = r_l;
            cur_d = r_l;
            if ((word_t'(r_l) == scm_w) || (word_t'(r_l) == maxl_w)) begin
              blink    = 1'b1;
              blink_ms = BLINK_RAMP_MS;
            end
          end
        end
        EV_CLICK_HOLD: begin
          if (rem_zero) begin
            v_w = cur_w - step_w;
            r_l = (cur_w > step_w) ? v_w[LEVEL_BITS-1:0] : LV_ONE;
            rem_d = r_l;
            tgt_d = r_l;
            cur_d = r_l;
            if ((word_t'(r_l) == scm_w) || (r_l == LV_ONE)) begin
              blink    = 1'b1;
              blink_ms = BLINK_RAMP_MS;
            end
          end
        end
        EV_TEMP_HIGH: begin
          if (cur_w > quarter_w) begin
            v_w = (cur_w > arg_w) ? (cur_w - arg_w) : '0;
            if (v_w < quarter_w) begin
              v_w = quarter_w;
            end
            cur_d = v_w[LEVEL_BITS-1:0];
          end
        end
        EV_TEMP_LOW: begin
          if (cur_w < tgt_w) begin
            v_w = cur_w + (arg_w >> 1);
            if (v_w > LMAX_W) begin
              v_w = LMAX_W;
            end
            if (v_w > tgt_w) begin
              v_w = tgt_w;
            end
            cur_d = v_w[LEVEL_BITS-1:0];
          end
        end
        default: handled = 1'b0;
      endcase
    end else if (mode_q == MODE_STROBE) begin
      unique case (ev_q)
        EV_TICK: begin
          if (frame_q == '0) begin
            pulsed   = 1'b1;
            pulse_ms = (gap_q < GAP_FAST_LIMIT) ? 5'd0 : 5'd1;
          end
          f_w = frame_q + GAP_BITS'(1);
          if (f_w > gap_q) begin
            f_w = '0;
          end
          frame_d = f_w;
        end
        EV_CLICK1: begin
          mode_d = MODE_OFF;
          cur_d  = '0;
        end
        EV_CLICK2: begin
          go_st  = 1'b1;
          st_lvl = rem_w;
        end
        EV_HOLD: begin
          if (rem_zero) begin
            g_w = {1'b0, gap_q} + (GAP_BITS+1)'(1);
            if (g_w >= GAP_WRAP) begin
              g_w = g_w - GAP_WRAP;
            end
            gap_d   = g_w[GAP_BITS-1:0];
            frame_d = '0;
          end
        end
        default: handled = 1'b0;
      endcase
    end else begin
      handled = 1'b0;
    end

    if (go_st) begin
      st_m = st_lvl[LEVEL_BITS-1:0];
      if ((word_t'(st_m) > ONE_W) && (word_t'(st_m) < maxl_w)) begin
        rem_d = st_m;
      end
      tgt_d  = st_m;
      cur_d  = st_m;
      mode_d = MODE_STEADY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxl_q <= MAX_LEVEL_RST;
      scm_q  <= SCM_RST;
      hold_q <= HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_LEVEL: maxl_q <= cfg_data_i;
        CFG_SCM:       scm_q  <= cfg_data_i;
        CFG_HOLD:      hold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OFF;
      cur_q    <= '0;
      rem_q    <= lvl_t'(SCM_RST);
      tgt_q    <= '0;
      coarse_q <= 1'b0;
      gap_q    <= GAP_RST;
      frame_q  <= '0;
    end else if (cmd_i.exec) begin
      mode_q   <= mode_d;
      cur_q    <= cur_d;
      rem_q    <= rem_d;
      tgt_q    <= tgt_d;
      coarse_q <= coarse_d;
      gap_q    <= gap_d;
      frame_q  <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ev_q  <= req_type_i;
      arg_q <= arg_i;
    end
    if (cmd_i.prep) begin
      step_q  <= step_c;
      sixth_q <= sixth_c;
    end
    if (cmd_i.exec) begin
      r_mode_q <= mode_d;
      r_unh_q  <= ~handled;
      r1_lvl_q <= cur_d;
      two_q    <= blink & ~pulsed;
      if (pulsed) begin
        r0_lvl_q   <= '0;
        r0_flash_q <= 1'b1;
        r0_hold_q  <= pulse_ms;
        r0_last_q  <= 1'b1;
      end else if (blink) begin
        r0_lvl_q   <= '0;
        r0_flash_q <= 1'b0;
        r0_hold_q  <= blink_ms;
        r0_last_q  <= 1'b0;
      end else begin
        r0_lvl_q   <= cur_d;
        r0_flash_q <= 1'b0;
        r0_hold_q  <= '0;
        r0_last_q  <= 1'b1;
      end
    end
  end

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_mode_q <= r_mode_q;
      out_unh_q  <= r_unh_q;
      if (cmd_i.out_sel) begin
        out_lvl_q   <= r1_lvl_q;
        out_flash_q <= 1'b0;
        out_hold_q  <= '0;
        out_last_q  <= 1'b1;
      end else begin
        out_lvl_q   <= r0_lvl_q;
        out_flash_q <= r0_flash_q;
        out_hold_q  <= r0_hold_q;
        out_last_q  <= r0_last_q;
      end
    end
  end

  assign stat_o.need_div = need_div;
  assign stat_o.div_busy = div_busy;
  assign stat_o.two_res  = two_q;
  assign stat_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign level_o     = out_lvl_q;
  assign flash_o     = out_flash_q;
  assign hold_ms_o   = out_hold_q;
  assign mode_o      = out_mode_q;
  assign unhandled_o = out_unh_q;
  assign last_o      = out_last_q;

endmodule

### hdl/flmc_ctrl.sv
module flmc_ctrl
  import flmc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  flmc_stat_t stat_i,
  output flmc_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_EXEC  = 6'b001000,
    ST_SEND0 = 6'b010000,
    ST_SEND1 = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
        if (accept) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep      = 1'b1;
        cmd_o.div_start = stat_i.need_div;
        state_d         = stat_i.need_div ? ST_DIV : ST_EXEC;
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_SEND0;
      end
      ST_SEND0: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = stat_i.two_res ? ST_SEND1 : ST_IDLE;
        end
      end
      ST_SEND1: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/flashlight_mode_controller.sv
// channel   direction  handshake                word
// input     in         in_valid_i / in_stall_o  req_type_i, arg_i
// output    out        out_valid_o / out_stall_i level_o, flash_o, hold_ms_o, mode_o,
//                                               unhandled_o, last_o
// config    in         cfg_we_i                 cfg_idx_i, cfg_data_i
//
// an accepted word passes prep, exec and send0 before its first result is in the
// output register; steady hold and click-hold, and strobe hold, also pass the div
// state of the 16-step remainder unit; a second result (blink then level) is sent
// from send1; the next word is taken once the last result sits in the output register
// rst_ni clears mode, current and target level and loads memo and register defaults
// out_stall_i holds the output register; input stays stalled until results are handed on
module flashlight_mode_controller
  import flmc_pkg::*;
#(
  parameter int LEVEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [IDX_BITS-1:0]   cfg_idx_i,
  input  logic [CFG_BITS-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [REQ_BITS-1:0]   req_type_i,
  input  logic [ARG_BITS-1:0]   arg_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LEVEL_BITS-1:0] level_o,
  output logic                  flash_o,
  output logic [HOLD_BITS-1:0]  hold_ms_o,
  output logic [MODE_BITS-1:0]  mode_o,
  output logic                  unhandled_o,
  output logic                  last_o
);

  flmc_cmd_t  cmd;
  flmc_stat_t stat;

  flmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  flmc_datapath #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_type_i  (req_type_i),
    .arg_i       (arg_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .level_o     (level_o),
    .flash_o     (flash_o),
    .hold_ms_o   (hold_ms_o),
    .mode_o      (mode_o),
    .unhandled_o (unhandled_o),
    .last_o      (last_o)
  );

endmodule

### hdl/flmc_checker.sv
module flmc_checker
  import flmc_pkg::*;
#(
  parameter int LEVEL_BITS = 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [LEVEL_BITS-1:0] level_o,
  input logic                  flash_o,
  input logic [HOLD_BITS-1:0]  hold_ms_o,
  input logic [MODE_BITS-1:0]  mode_o,
  input logic                  unhandled_o,
  input logic                  last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(level_o) && $stable(last_o)
      && $stable(hold_ms_o) && $stable(flash_o))
    else $error("stalled result changed");

  // one word in flight at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in work");

  // a strobe pulse is the only result of its word and only in strobe mode
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flash_o |-> level_o == '0 && last_o && !unhandled_o
      && mode_o == MODE_STROBE)
    else $error("bad strobe pulse");

  // a non-final result is always a dark blink
  a_blink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> level_o == '0 && !flash_o && !unhandled_o
      && (hold_ms_o == BLINK_RAMP_MS || hold_ms_o == BLINK_FOUR_MS))
    else $error("bad blink result");

endmodule

bind flashlight_mode_controller flmc_checker #(.LEVEL_BITS(LEVEL_BITS)) u_flmc_checker (.*);

### tb/flashlight_mode_controller_tb.sv
module flashlight_mode_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import flmc_pkg::*;

  localparam int LVL_BITS     = 8;
  localparam int CLK_PERIOD   = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int TIMEOUT_NS   = 10_000_000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [REQ_BITS-1:0] EV_UNUSED = 4'd15;

  localparam logic [HOLD_BITS-1:0] EDGE_BLINK_MS  = 5'd7;
  localparam logic [HOLD_BITS-1:0] FOUR_CLICK_MS  = 5'd20;
  localparam logic [HOLD_BITS-1:0] PULSE_FAST_MS  = 5'd0;
  localparam logic [HOLD_BITS-1:0] PULSE_SLOW_MS  = 5'd1;

  localparam logic [REQ_BITS-1:0] OFF_STARTS [8] = '{
    EV_PRESS, EV_RELEASE, EV_CLICK1, EV_CLICK2,
    EV_CLICK3, EV_HOLD, EV_HOLD_REL, EV_CLICK_HOLD
  };

  // fixed register settings of the sweep, extremes first
  localparam logic [CFG_BITS-1:0] SWEEP_MAX  [5] = '{8'd8, 8'd255, 8'd255, 8'd8, 8'd100};
  localparam logic [CFG_BITS-1:0] SWEEP_SCM  [5] = '{8'd1, 8'd255, 8'd1, 8'd8, 8'd50};
  localparam logic [CFG_BITS-1:0] SWEEP_HOLD [5] = '{8'd1, 8'd255, 8'd0, 8'd255, 8'd3};

  typedef struct packed {
    logic [LVL_BITS-1:0]  level;
    logic                 flash;
    logic [HOLD_BITS-1:0] hold_ms;
    logic [MODE_BITS-1:0] mode;
    logic                 unhandled;
    logic                 last;
  } light_word_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [IDX_BITS-1:0]   cfg_idx_i   = '0;
  logic [CFG_BITS-1:0]   cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [REQ_BITS-1:0]   req_type_i  = '0;
  logic [ARG_BITS-1:0]   arg_i       = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [LVL_BITS-1:0]   level_o;
  logic                  flash_o;
  logic [HOLD_BITS-1:0]  hold_ms_o;
  logic [MODE_BITS-1:0]  mode_o;
  logic                  unhandled_o;
  logic                  last_o;

  flashlight_mode_controller #(
    .LEVEL_BITS(LVL_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .arg_i      (arg_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .level_o    (level_o),
    .flash_o    (flash_o),
    .hold_ms_o  (hold_ms_o),
    .mode_o     (mode_o),
    .unhandled_o(unhandled_o),
    .last_o     (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predicted light state and register copies
  logic [CFG_BITS-1:0]  reg_max, reg_scm, reg_hold;
  logic [MODE_BITS-1:0] pred_mode;
  logic [LVL_BITS-1:0]  pred_level, pred_memo, pred_target;
  logic                 pred_coarse;
  logic [GAP_BITS-1:0]  pred_gap, pred_frame;

  logic [LVL_BITS-1:0]  step_lvl [2];
  logic                 step_flash [2];
  logic [HOLD_BITS-1:0] step_ms [2];
  int                   step_n;

  light_word_t light_words_q [$];

  bit          calm;
  int unsigned stall_left;
  int          errors;
  int unsigned events_sent, handled_events, words_seen, pulses_seen, blinks_seen;
  int unsigned settings_used;

  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned ramp_step();
    int unsigned s;
    s = reg_max / 6;
    if (!pred_coarse || s == 0) s = 1;
    return s;
  endfunction

  task automatic enter_steady(input logic [LVL_BITS-1:0] lvl);
    if (lvl > 1 && lvl < reg_max) pred_memo = lvl;
    pred_target = lvl;
    pred_level  = lvl;
    pred_mode   = MODE_STEADY;
  endtask

  task automatic enter_off();
    pred_mode  = MODE_OFF;
    pred_level = '0;
  endtask

  task automatic enter_strobe();
    pred_frame = '0;
    pred_mode  = MODE_STROBE;
  endtask

  task automatic add_word(input logic [LVL_BITS-1:0] lvl, input logic fl,
                          input logic [HOLD_BITS-1:0] ms);
    if (step_n < 2) begin
      step_lvl[step_n]   = lvl;
      step_flash[step_n] = fl;
      step_ms[step_n]    = ms;
      step_n++;
    end
  endtask

  task automatic predict_light(input logic [REQ_BITS-1:0] req, input logic [ARG_BITS-1:0] arg);
    light_word_t w;
    int unsigned stp, per, sum;
    logic        known, pulsed;
    step_n = 0;
    known  = 1'b1;
    pulsed = 1'b0;
    stp    = ramp_step();
    if (req == EV_LOW_VOLT) begin
      if (pred_mode == MODE_STROBE) begin
        enter_steady(LVL_BITS'(reg_max / 6));
      end else if (pred_mode == MODE_STEADY) begin
        if (pred_level > 1) pred_level = pred_level >> 1;
        else enter_off();
      end
    end else if (pred_mode == MODE_OFF) begin
      case (req)
        EV_PRESS:                pred_level = LVL_BITS'(1);
        EV_RELEASE:              pred_level = pred_memo;
        EV_CLICK1:               enter_steady(pred_memo);
        EV_CLICK2, EV_CLICK_HOLD: enter_steady(reg_max);
        EV_CLICK3:               enter_strobe();
        EV_HOLD:                 if (arg >= reg_hold) enter_steady(LVL_BITS'(1));
        EV_HOLD_REL:             enter_steady(LVL_BITS'(1));
        default:                 known = 1'b0;
      endcase
    end else if (pred_mode == MODE_STEADY) begin
      case (req)
        EV_CLICK1: enter_off();
        EV_CLICK2: begin
          // turbo toggle: below max remembers the level, at max goes back
          if (pred_level < reg_max) begin
            pred_memo   = pred_level;
            pred_target = reg_max;
          end else begin
            pred_target = pred_memo;
          end
          pred_level = pred_target;
        end
        EV_CLICK3: enter_strobe();
        EV_CLICK4: begin
          pred_coarse = ~pred_coarse;
          add_word('0, 1'b0, FOUR_CLICK_MS);
          pred_level = pred_memo;
        end
        EV_HOLD: begin
          if (arg % stp == 0) begin
            sum         = pred_level + stp;
            pred_memo   = (sum < reg_max) ? LVL_BITS'(sum) : reg_max;
            pred_target = pred_memo;
            if (pred_memo == reg_scm || pred_memo == reg_max)
              add_word('0, 1'b0, EDGE_BLINK_MS);
            pred_level = pred_memo;
          end
        end
        EV_CLICK_HOLD: begin
          if (arg % stp == 0) begin
            pred_memo   = (pred_level > stp) ? LVL_BITS'(pred_level - stp) : LVL_BITS'(1);
            pred_target = pred_memo;
            if (pred_memo == reg_scm || pred_memo == 1)
              add_word('0, 1'b0, EDGE_BLINK_MS);
            pred_level = pred_memo;
          end
        end
        EV_TEMP_HIGH: begin
          if (pred_level > reg_max / 4) begin
            sum = (pred_level > arg) ? pred_level - arg : 0;
            if (sum < reg_max / 4) sum = reg_max / 4;
            pred_level = LVL_BITS'(sum);
          end
        end
        EV_TEMP_LOW: begin
          if (pred_level < pred_target) begin
            sum = pred_level + (arg >> 1);
            if (sum > 255) sum = 255;
            if (sum > pred_target) sum = 32'(pred_target);
            pred_level = LVL_BITS'(sum);
          end
        end
        default: known = 1'b0;
      endcase
    end else if (pred_mode == MODE_STROBE) begin
      case (req)
        EV_TICK: begin
          if (pred_frame == 0) begin
            add_word('0, 1'b1, (pred_gap < 3) ? PULSE_FAST_MS : PULSE_SLOW_MS);
            pulsed = 1'b1;
          end
          pred_frame = pred_frame + 3'd1;
          if (pred_frame > pred_gap) pred_frame = '0;
        end
        EV_CLICK1: enter_off();
        EV_CLICK2: enter_steady(pred_memo);
        EV_HOLD: begin
          per = (reg_hold != 0) ? reg_hold : 1;
          if (arg % per == 0) begin
            pred_gap   = GAP_BITS'((int'(pred_gap) + 1) % 6);
            pred_frame = '0;
          end
        end
        default: known = 1'b0;
      endcase
    end else begin
      known = 1'b0;
    end
    if (!pulsed) add_word(pred_level, 1'b0, '0);
    for (int k = 0; k < step_n; k++) begin
      w.level     = step_lvl[k];
      w.flash     = step_flash[k];
      w.hold_ms   = step_ms[k];
      w.mode      = pred_mode;
      w.unhandled = ~known;
      w.last      = (k == step_n - 1);
      light_words_q.push_back(w);
    end
    if (known) handled_events++;
  endtask

  task automatic send_event(input logic [REQ_BITS-1:0] req, input logic [ARG_BITS-1:0] arg);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 99) < 45) ? 0 : pick_pause();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    arg_i      <= arg;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    events_sent++;
    predict_light(req, arg);
  endtask

  // drop valid and wait for every due word plus the block's latency
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (light_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  task automatic write_setting(input logic [CFG_BITS-1:0] max_lvl, input logic [CFG_BITS-1:0] scm,
                               input logic [CFG_BITS-1:0] hold);
    settle();
    write_reg(CFG_MAX_LEVEL, max_lvl);
    write_reg(CFG_SCM, scm);
    write_reg(CFG_HOLD, hold);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reg_max  = max_lvl;
    reg_scm  = scm;
    reg_hold = hold;
    settings_used++;
  endtask

  task automatic random_event();
    logic [REQ_BITS-1:0] req;
    logic [ARG_BITS-1:0] arg;
    int unsigned         r, stp, per, n;
    r   = $urandom_range(0, 99);
    stp = ramp_step();
    per = (reg_hold != 0) ? reg_hold : 1;
    arg = ARG_BITS'($urandom_range(0, 40));
    req = EV_TICK;
    if ($urandom_range(0, 99) < 3) calm = !calm;
    if (r < 12) begin
      req = REQ_BITS'($urandom_range(0, 15));
      arg = ARG_BITS'($urandom());
    end else if (pred_mode == MODE_OFF) begin
      req = OFF_STARTS[$urandom_range(0, 7)];
      arg = ARG_BITS'($urandom_range(0, reg_hold + 3));
    end else if (pred_mode == MODE_STEADY) begin
      if (r < 22) begin
        // a held button: a run of words, each one ramp step
        n   = $urandom_range(3, 30);
        req = (r < 17) ? EV_HOLD : EV_CLICK_HOLD;
        for (int i = 0; i < n; i++) send_event(req, ARG_BITS'(i * stp));
        return;
      end else if (r < 45) begin
        req = $urandom_range(0, 1) ? EV_HOLD : EV_CLICK_HOLD;
        arg = ARG_BITS'($urandom_range(0, 20) * stp + $urandom_range(0, 1));
      end else if (r < 65) begin
        req = (r < 55) ? EV_TEMP_HIGH : EV_TEMP_LOW;
        arg = ARG_BITS'(($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 60));
      end else if (r < 75) begin
        req = EV_CLICK2;
      end else if (r < 80) begin
        req = EV_CLICK4;
      end else if (r < 86) begin
        req = EV_LOW_VOLT;
      end else if (r < 93) begin
        req = EV_CLICK3;
      end else begin
        req = EV_CLICK1;
      end
    end else begin
      if (r < 70) begin
        req = EV_TICK;
      end else if (r < 84) begin
        req = EV_HOLD;
        arg = ARG_BITS'($urandom_range(0, 1) ? $urandom_range(0, 3) * per : $urandom());
      end else if (r < 89) begin
        req = EV_LOW_VOLT;
      end else if (r < 95) begin
        req = EV_CLICK2;
      end else begin
        req = EV_CLICK1;
      end
    end
    send_event(req, arg);
  endtask

  task automatic test_off_events();
    send_event(EV_PRESS, 16'hFFFF);
    send_event(EV_RELEASE, '0);
    send_event(EV_UNUSED, '0);
    send_event(EV_CLICK4, '0);
    send_event(EV_TICK, '0);
    send_event(EV_LOW_VOLT, '0);
    send_event(EV_HOLD, 16'(reg_hold - 1));
    send_event(EV_HOLD, 16'(reg_hold));
  endtask

  task automatic test_steady_ramp();
    send_event(EV_CLICK_HOLD, '0);
    send_event(EV_HOLD, '0);
    send_event(EV_CLICK2, '0);
    send_event(EV_HOLD, '0);
    send_event(EV_CLICK4, '0);
    send_event(EV_HOLD, 16'd7);
    send_event(EV_CLICK_HOLD, 16'd50);
    send_event(EV_PRESS, '0);
  endtask

  task automatic test_thermal_and_low_voltage();
    send_event(EV_TEMP_HIGH, 16'hFFFF);
    send_event(EV_TEMP_LOW, 16'hFFFF);
    send_event(EV_LOW_VOLT, '0);
    send_event(EV_CLICK4, '0);
  endtask

  task automatic test_strobe();
    send_event(EV_CLICK3, '0);
    send_event(EV_TICK, '0);
    send_event(EV_TICK, '0);
    send_event(EV_HOLD, 16'd48);
    send_event(EV_TICK, '0);
    send_event(EV_RELEASE, '0);
    send_event(EV_LOW_VOLT, '0);
    send_event(EV_CLICK1, '0);
    send_event(EV_HOLD_REL, '0);
    send_event(EV_LOW_VOLT, '0);
  endtask

  task automatic test_settings_sweep();
    int unsigned goal;
    for (int p = 0; p < 9; p++) begin
      if (p > 0 && p <= 5)
        write_setting(SWEEP_MAX[p-1], SWEEP_SCM[p-1], SWEEP_HOLD[p-1]);
      else if (p > 5)
        write_setting(CFG_BITS'($urandom_range(8, 255)), CFG_BITS'($urandom_range(1, 255)),
                      CFG_BITS'($urandom_range(1, 255)));
      calm = 1'b0;
      goal = events_sent + 140;
      while (events_sent < goal) random_event();
    end
  endtask

  // output side back-pressure
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 30) begin
      stall_left = pick_pause() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_words
    light_word_t want, seen;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      seen.level     = level_o;
      seen.flash     = flash_o;
      seen.hold_ms   = hold_ms_o;
      seen.mode      = mode_o;
      seen.unhandled = unhandled_o;
      seen.last      = last_o;
      words_seen++;
      if (seen.flash === 1'b1) pulses_seen++;
      else if (seen.hold_ms != 0) blinks_seen++;
      if (light_words_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: word with nothing due: level %0d flash %0b hold %0d mode %0d",
                   $realtime, seen.level, seen.flash, seen.hold_ms, seen.mode);
      end else begin
        want = light_words_q.pop_front();
        if (seen.level !== want.level || seen.flash !== want.flash ||
            seen.hold_ms !== want.hold_ms || seen.mode !== want.mode ||
            seen.unhandled !== want.unhandled || seen.last !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: word %0d exp lvl %0d fl %0b ms %0d md %0d unh %0b last %0b, got lvl %0d fl %0b ms %0d md %0d unh %0b last %0b",
                     $realtime, words_seen, want.level, want.flash, want.hold_ms, want.mode,
                     want.unhandled, want.last, seen.level, seen.flash, seen.hold_ms, seen.mode,
                     seen.unhandled, seen.last);
        end
      end
    end
  end

  initial begin
    reg_max     = MAX_LEVEL_RST;
    reg_scm     = SCM_RST;
    reg_hold    = HOLD_RST;
    pred_mode   = MODE_OFF;
    pred_level  = '0;
    pred_memo   = SCM_RST;
    pred_target = '0;
    pred_coarse = 1'b0;
    pred_gap    = GAP_RST;
    pred_frame  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_off_events();
    test_steady_ramp();
    test_thermal_and_low_voltage();
    test_strobe();
    test_settings_sweep();

    settle();
    if (light_words_q.size() != 0) begin
      errors += light_words_q.size();
      $display("%0d words still due at the end", light_words_q.size());
    end
    $display("%0d events sent, %0d acted on, across %0d register settings after the defaults",
             events_sent, handled_events, settings_used);
    $display("%0d words checked: %0d strobe pulses, %0d blinks; %0d mismatches",
             words_seen, pulses_seen, blinks_seen, errors);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d words still due", light_words_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
hdl/flmc_pkg.sv
hdl/flmc_mod.sv
hdl/flmc_datapath.sv
hdl/flmc_ctrl.sv
hdl/flashlight_mode_controller.sv
hdl/flmc_checker.sv
tb/flashlight_mode_controller_tb.sv
